[rtl/versioned_selection_table_assert.svh]
// assertion macros used by vst_back
`ifndef VERSIONED_SELECTION_TABLE_ASSERT_SVH
`define VERSIONED_SELECTION_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define VST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vst assertion failed");
`define VST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("vst forbidden condition");
`else
`define VST_ASSERT(lbl, prop)
`define VST_NEVER(lbl, cond)
`endif
`endif

[rtl/vst_pkg.sv]
`default_nettype none
package vst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int QDEPTH = 2;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [7:0] CFG_CAP = 8'd0;
  localparam logic [7:0] CFG_CRTC = 8'd1;
  localparam logic [7:0] CFG_INIT_ID = 8'd2;
  localparam logic [7:0] CFG_INIT_TAG = 8'd3;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_WITHDRAW = 4'd1, OP_FORGET = 4'd2, OP_SUGGEST = 4'd3,
    OP_LOOKUP = 4'd4, OP_CHECK = 4'd5, OP_ACCEPT = 4'd6, OP_QUIESCE = 4'd7,
    OP_CLOSE = 4'd8, OP_SELECTED = 4'd9, OP_SNAPSHOT = 4'd10
  } op_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_INVALID = 4'd1, ST_STALE = 4'd2, ST_EXISTS = 4'd3,
    ST_NOSPACE = 4'd4, ST_OVERFLOW = 4'd5, ST_NOTFOUND = 4'd6, ST_BUSY = 4'd7,
    ST_CBERR = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_SHIFT, S_RESP, S_SNAP
  } state_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] id;
    logic [15:0] tag;
    logic [31:0] crtc;
    logic        in_dom;
    logic        present;
    logic        cb_fail;
    logic [63:0] expect_gen;
    logic        scan;
    logic        key_chosen;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  status;
    logic [63:0] id;
    logic [15:0] tag;
    logic        sel;
    logic [63:0] generation;
    logic [63:0] selected;
    logic [63:0] suggested;
    logic [4:0]  count;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

[rtl/versioned_selection_table.sv]
`default_nettype none
// Versioned selection table. A request is taken when start_i is high and busy_o
// is low; busy_o rises only when the two-entry request queue is full. Each
// request is executed one at a time by the back end: a dispatch step, a key
// search through the entries (for all ops but close and snapshot), then an
// execute step and a response step. forget adds a shift step that moves the
// later entries down by one slot; a snapshot takes a dispatch and an execute
// step, then emits one result per entry, one per cycle. Results appear on
// the result ports for exactly one cycle with res_valid_o high and cannot be
// stalled; last_o marks the final result of a request. Configuration writes are
// always taken (cfg_ready_o is high) and must be issued only while no request
// is open.
module versioned_selection_table import vst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [63:0] entry_id_i,
  input  wire logic [15:0] entry_tag_i,
  input  wire logic [31:0] entry_crtc_i,
  input  wire logic        entry_in_domain_i,
  input  wire logic        entry_present_i,
  input  wire logic        callback_failed_i,
  input  wire logic [63:0] expected_generation_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             res_valid_o,
  output logic [3:0]       status_o,
  output logic [63:0]      out_id_o,
  output logic [15:0]      out_tag_o,
  output logic             out_selectable_o,
  output logic [63:0]      out_generation_o,
  output logic [63:0]      out_selected_o,
  output logic [63:0]      out_suggested_o,
  output logic [4:0]       out_count_o,
  output logic             last_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res;

  assign cfg_ready_o = 1'b1;

  // request queue and classification
  vst_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .entry_id_i, .entry_tag_i,
    .entry_crtc_i, .entry_in_domain_i, .entry_present_i, .callback_failed_i,
    .expected_generation_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // table and execution
  vst_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .res_o(res)
  );

  assign res_valid_o = res.valid;
  assign status_o = res.status;
  assign out_id_o = res.id;
  assign out_tag_o = res.tag;
  assign out_selectable_o = res.sel;
  assign out_generation_o = res.generation;
  assign out_selected_o = res.selected;
  assign out_suggested_o = res.suggested;
  assign out_count_o = res.count;
  assign last_o = res.last;

endmodule
`default_nettype wire

[rtl/vst_front.sv]
`default_nettype none
module vst_front import vst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [63:0] entry_id_i,
  input  wire logic [15:0] entry_tag_i,
  input  wire logic [31:0] entry_crtc_i,
  input  wire logic        entry_in_domain_i,
  input  wire logic        entry_present_i,
  input  wire logic        callback_failed_i,
  input  wire logic [63:0] expected_generation_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_pop_i
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  cmd_t             cls;
  logic             push, pop;

  // classify the request: which ops search the table and by which key
  always_comb begin
    cls = '0;
    cls.op = op_i;
    cls.id = entry_id_i;
    cls.tag = entry_tag_i;
    cls.crtc = entry_crtc_i;
    cls.in_dom = entry_in_domain_i;
    cls.present = entry_present_i;
    cls.cb_fail = callback_failed_i;
    cls.expect_gen = expected_generation_i;
    cls.scan = (op_i <= OP_SELECTED) && (op_i != OP_CLOSE);
    cls.key_chosen = (op_i == OP_QUIESCE) || (op_i == OP_SELECTED);
  end

  assign busy_o = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign push = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop = cmd_pop_i && cmd_valid_o;
  assign cmd_o = mem_q[rd_q];

  // queue pointers
  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

[rtl/vst_back.sv]
`default_nettype none
`include "versioned_selection_table_assert.svh"
module vst_back import vst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output res_t             res_o
);

  state_e state_q, state_d;

  logic [63:0]      slot_id_q  [CAPACITY];
  logic [15:0]      slot_tag_q [CAPACITY];
  logic [CAPACITY-1:0] slot_sel_q;

  logic [4:0]       cap_q;
  logic [31:0]      crtc_q;
  logic [CNT_W-1:0] used_q;
  logic [63:0]      version_q, chosen_q, hinted_q;
  logic             shut_q;

  cmd_t             cmd_q;
  logic [CNT_W-1:0] idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_ix_q;
  logic [3:0]       stat_q;
  logic [63:0]      ent_id_q;
  logic [15:0]      ent_tag_q;
  logic             ent_sel_q;

  logic [CNT_W-1:0] idx_inc;
  logic [IDX_W-1:0] rd_addr;
  logic [63:0]      rd_id, key;
  logic [15:0]      rd_tag;
  logic             rd_sel;
  logic [CNT_W-1:0] limit;
  logic             vmax, scan_end, scan_hit, shift_more, snap_last;

  // execute decisions
  status_e ex_st, vst;
  logic    ex_ent, do_add, do_wd, do_hint, do_accept, do_close, do_forget, do_snap;

  assign idx_inc = idx_q + 1'b1;
  assign vmax = (version_q == U64_MAX);
  assign key = cmd_q.key_chosen ? chosen_q : cmd_q.id;

  // single table read port, address chosen by state
  always_comb begin
    case (state_q)
      S_EXEC:  rd_addr = hit_ix_q;
      S_SHIFT: rd_addr = idx_inc[IDX_W-1:0];
      default: rd_addr = idx_q[IDX_W-1:0];
    endcase
  end
  assign rd_id = slot_id_q[rd_addr];
  assign rd_tag = slot_tag_q[rd_addr];
  assign rd_sel = slot_sel_q[rd_addr];

  assign scan_end = (idx_q == used_q);
  assign scan_hit = !scan_end && (rd_id == key);
  assign shift_more = (idx_inc < used_q);
  assign snap_last = (idx_inc == used_q);

  // effective capacity
  always_comb begin
    if (int'(cap_q) > CAPACITY) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(cap_q);
    end
  end

  // entry validation for check, accept and lookup
  always_comb begin
    logic [15:0] vtag;
    vtag = (cmd_q.op == OP_LOOKUP) ? rd_tag : cmd_q.tag;
    if (shut_q) begin
      vst = ST_STALE;
    end else if (!cmd_q.present && cmd_q.op != OP_LOOKUP) begin
      vst = ST_INVALID;
    end else if (!hit_q || rd_tag != vtag) begin
      vst = ST_STALE;
    end else if (!rd_sel && chosen_q != cmd_q.id) begin
      vst = ST_STALE;
    end else begin
      vst = ST_OK;
    end
  end

  // operation decode in the execute cycle
  always_comb begin
    ex_st = ST_OK;
    ex_ent = 1'b0;
    do_add = 1'b0;
    do_wd = 1'b0;
    do_hint = 1'b0;
    do_accept = 1'b0;
    do_close = 1'b0;
    do_forget = 1'b0;
    do_snap = 1'b0;
    case (cmd_q.op)
      OP_ADD: begin
        if (!cmd_q.present || !cmd_q.in_dom || cmd_q.crtc != crtc_q) ex_st = ST_INVALID;
        else if (shut_q) ex_st = ST_STALE;
        else if (hit_q) ex_st = ST_EXISTS;
        else if (used_q >= limit) ex_st = ST_NOSPACE;
        else if (vmax) ex_st = ST_OVERFLOW;
        else do_add = 1'b1;
      end
      OP_WITHDRAW: begin
        if (!hit_q) ex_st = ST_NOTFOUND;
        else if (!rd_sel) ex_st = ST_OK;
        else if (vmax) ex_st = ST_OVERFLOW;
        else do_wd = 1'b1;
      end
      OP_FORGET: begin
        if (!hit_q) ex_st = ST_NOTFOUND;
        else if (rd_sel || chosen_q == cmd_q.id) ex_st = ST_BUSY;
        else if (vmax) ex_st = ST_OVERFLOW;
        else do_forget = 1'b1;
      end
      OP_SUGGEST: begin
        if (shut_q) ex_st = ST_STALE;
        else if (cmd_q.id != '0 && (!hit_q || !rd_sel)) ex_st = ST_STALE;
        else if (hinted_q == cmd_q.id) ex_st = ST_OK;
        else if (vmax) ex_st = ST_OVERFLOW;
        else do_hint = 1'b1;
      end
      OP_LOOKUP: begin
        if (cmd_q.id == '0) ex_st = ST_INVALID;
        else if (!hit_q) ex_st = ST_STALE;
        else begin
          ex_st = vst;
          ex_ent = (vst == ST_OK);
        end
      end
      OP_CHECK: begin
        if (vst != ST_OK) ex_st = vst;
        else if (cmd_q.cb_fail) ex_st = ST_CBERR;
      end
      OP_ACCEPT: begin
        if (vst != ST_OK) ex_st = vst;
        else if (chosen_q != cmd_q.id && vmax) ex_st = ST_OVERFLOW;
        else if (cmd_q.cb_fail) ex_st = ST_CBERR;
        else do_accept = (chosen_q != cmd_q.id);
      end
      OP_QUIESCE: begin
        if (!hit_q || !cmd_q.present || chosen_q != cmd_q.id || rd_tag != cmd_q.tag) begin
          ex_st = ST_STALE;
        end else if (cmd_q.cb_fail) ex_st = ST_CBERR;
      end
      OP_CLOSE: do_close = 1'b1;
      OP_SELECTED: begin
        if (!hit_q) ex_st = ST_NOTFOUND;
        else ex_ent = 1'b1;
      end
      OP_SNAPSHOT: begin
        if (shut_q || (cmd_q.expect_gen != '0 && cmd_q.expect_gen != version_q)) begin
          ex_st = ST_STALE;
        end else do_snap = 1'b1;
      end
      default: ex_st = ST_INVALID;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) state_d = cmd_i.scan ? S_SCAN : S_EXEC;
      end
      S_SCAN: begin
        if (scan_end || scan_hit) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (do_forget) state_d = S_SHIFT;
        else if (do_snap) state_d = (used_q == '0) ? S_IDLE : S_SNAP;
        else state_d = S_RESP;
      end
      S_SHIFT: begin
        if (!shift_more) state_d = S_RESP;
      end
      S_RESP: state_d = S_IDLE;
      S_SNAP: begin
        if (snap_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o = (state_q == S_IDLE);
    res_o = '0;
    res_o.generation = version_q;
    res_o.selected = chosen_q;
    res_o.suggested = hinted_q;
    res_o.count = 5'(used_q);
    case (state_q)
      S_RESP: begin
        res_o.valid = 1'b1;
        res_o.status = stat_q;
        res_o.id = ent_id_q;
        res_o.tag = ent_tag_q;
        res_o.sel = ent_sel_q;
        res_o.last = 1'b1;
      end
      S_SNAP: begin
        res_o.valid = 1'b1;
        res_o.status = ST_OK;
        res_o.id = rd_id;
        res_o.tag = rd_tag;
        res_o.sel = rd_sel;
        res_o.last = snap_last;
      end
      default: ;
    endcase
  end

  // control state and table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q <= 5'd16;
      crtc_q <= '0;
      used_q <= CNT_W'(1);
      version_q <= 64'd1;
      chosen_q <= 64'd1;
      hinted_q <= '0;
      shut_q <= 1'b0;
      slot_sel_q <= CAPACITY'(1);
      idx_q <= '0;
      hit_q <= 1'b0;
      hit_ix_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_id_q[i] <= '0;
        slot_tag_q[i] <= '0;
      end
      slot_id_q[0] <= 64'd1;
    end else begin
      state_q <= state_d;
      // configuration writes; the user must issue them only while idle, the block has no check for it
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CAP: cap_q <= cfg_data_i[4:0];
          CFG_CRTC: crtc_q <= cfg_data_i[31:0];
          CFG_INIT_ID: begin
            if (version_q == 64'd1) begin
              slot_id_q[0] <= cfg_data_i;
              chosen_q <= cfg_data_i;
            end
          end
          CFG_INIT_TAG: begin
            if (version_q == 64'd1) slot_tag_q[0] <= cfg_data_i[15:0];
          end
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          hit_q <= 1'b0;
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit_q <= 1'b1;
            hit_ix_q <= idx_q[IDX_W-1:0];
          end else if (!scan_end) begin
            idx_q <= idx_inc;
          end
        end
        S_EXEC: begin
          idx_q <= do_forget ? CNT_W'(hit_ix_q) : '0;
          if (do_add) begin
            slot_id_q[used_q[IDX_W-1:0]] <= cmd_q.id;
            slot_tag_q[used_q[IDX_W-1:0]] <= cmd_q.tag;
            slot_sel_q[used_q[IDX_W-1:0]] <= 1'b1;
            used_q <= used_q + 1'b1;
          end
          if (do_wd) begin
            slot_sel_q[hit_ix_q] <= 1'b0;
            if (hinted_q == cmd_q.id) hinted_q <= '0;
          end
          if (do_hint) hinted_q <= cmd_q.id;
          if (do_accept) chosen_q <= cmd_q.id;
          if (do_close) shut_q <= 1'b1;
          if (do_add || do_wd || do_hint || do_accept) version_q <= version_q + 1'b1;
        end
        S_SHIFT: begin
          if (shift_more) begin
            slot_id_q[idx_q[IDX_W-1:0]] <= rd_id;
            slot_tag_q[idx_q[IDX_W-1:0]] <= rd_tag;
            slot_sel_q[idx_q[IDX_W-1:0]] <= rd_sel;
            idx_q <= idx_inc;
          end else begin
            slot_sel_q[idx_q[IDX_W-1:0]] <= 1'b0;
            used_q <= used_q - 1'b1;
            version_q <= version_q + 1'b1;
          end
        end
        S_SNAP: idx_q <= idx_inc;
        default: ;
      endcase
    end
  end

  // request capture and response fields
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == S_EXEC) begin
      stat_q <= ex_st;
      ent_id_q <= ex_ent ? rd_id : '0;
      ent_tag_q <= ex_ent ? rd_tag : '0;
      ent_sel_q <= ex_ent ? rd_sel : 1'b0;
    end
  end

  `VST_NEVER(a_used_bound, used_q > CNT_W'(CAPACITY))
  `VST_ASSERT(a_version_mono, version_q >= $past(version_q))
  `VST_ASSERT(a_shut_sticky, $past(shut_q) |-> shut_q)

endmodule
`default_nettype wire
